[hdl/aptq_pkg.sv]
// ----------------------------------------------------------------------------
// aptq_pkg
// Shared types and constants for the adaptive priority transmit queue.
// ----------------------------------------------------------------------------
package aptq_pkg;

	localparam int NORMAL_DEPTH    = 512;
	localparam int EXPEDITED_DEPTH = 64;
	localparam int LIMIT_FLOOR     = 20;

	localparam int NAW = $clog2(NORMAL_DEPTH);
	localparam int EAW = $clog2(EXPEDITED_DEPTH);
	localparam int NCW = NAW + 1;
	localparam int ECW = EAW + 1;
	localparam int DW  = 49;

	localparam logic [2:0] ST_ACCEPTED = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_DEQUEUED = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_BYPASS   = 3'd4;

	localparam logic [2:0] REG_ASYNC  = 3'd0;
	localparam logic [2:0] REG_LIMIT  = 3'd1;
	localparam logic [2:0] REG_RESIZE = 3'd2;
	localparam logic [2:0] REG_DELAY  = 3'd3;
	localparam logic [2:0] REG_RATE   = 3'd4;

	// Divider request / reply
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [47:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;

endpackage

[hdl/aptq_ram.sv]
// ----------------------------------------------------------------------------
// aptq_ram
// Generic single-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
module aptq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[hdl/aptq_div.sv]
// ----------------------------------------------------------------------------
// aptq_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aptq_div (
	input  logic                clk,
	input  logic                arst_n,
	input  aptq_pkg::div_req_t  req,
	output aptq_pkg::div_rsp_t  rsp
);
	import aptq_pkg::*;

	logic [63:0] quo_q;
	logic [48:0] rem_q;
	logic [47:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [48:0] trial;
	logic [48:0] diff;

	assign trial = {rem_q[47:0], quo_q[63]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!diff[48]) begin
				rem_q <= diff;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divider restarted while busy");
	a_busy_counts: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != 7'd0) else $error("divider count underflow");
endmodule

[hdl/adaptive_priority_tx_queue.sv]
// ----------------------------------------------------------------------------
// adaptive_priority_tx_queue
// Two-class transmit descriptor queue with strict priority and adaptive limit.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; one result strobe
// (done) follows and the receiver cannot stall it. An item that needs no
// scaled level (async off or a zero limit) passes through the store read
// and then the output register. Any other item runs the scaled level
// through one shared 64-step bit-serial divider. A dequeue with auto-resize
// first divides for the bound on the same divider, unless the dequeued
// length is zero, and then updates the adaptive limit.
module adaptive_priority_tx_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic        expedited,
	input  logic [31:0] dest_addr,
	input  logic [15:0] msg_length,
	input  logic        wants_level,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] out_addr,
	output logic [15:0] out_length,
	output logic        out_wants_level,
	output logic        out_from_expedited,
	output logic [7:0]  scaled_level,
	output logic [9:0]  normal_count,
	output logic [9:0]  current_limit
);
	import aptq_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_READ  = 7'b0000010,
		S_MUL   = 7'b0000100,
		S_BOUND = 7'b0001000,
		S_LEVEL = 7'b0010000,
		S_WAITL = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;

	logic        async_q, resize_q;
	logic [9:0]  qlimit_q, alimit_q;
	logic [15:0] delay_q;
	logic [31:0] rate_q;

	logic [NAW-1:0] nhead_q;
	logic [NCW-1:0] nocc_q;
	logic [EAW-1:0] ehead_q;
	logic [ECW-1:0] eocc_q;

	logic [31:0] addr_q;
	logic [15:0] len_q;
	logic        from_exp_q;
	logic [2:0]  st_q;
	logic [47:0] num_q;
	logic [DW-1:0] desc_q;
	logic        done_q;

	logic [DW-1:0] n_rdata, e_rdata;
	logic          n_we, e_we;
	logic [NAW-1:0] n_waddr;
	logic [EAW-1:0] e_waddr;
	logic [DW-1:0]  wdesc;

	div_req_t dreq;
	div_rsp_t drsp;

	logic cfg_wr;
	logic take;
	logic n_room;
	logic [NCW:0] nsum;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign take   = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign wdesc  = {dest_addr, msg_length, wants_level};

	assign nsum    = {1'b0, nhead_q} + {1'b0, nocc_q};
	assign n_waddr = nsum[NAW-1:0];
	assign e_waddr = ehead_q + eocc_q[EAW-1:0];
	assign n_room  = (alimit_q == 10'd0 || {1'b0, nocc_q} < {1'b0, alimit_q})
		&& nocc_q < NCW'(NORMAL_DEPTH);
	assign n_we = take && !func && async_q && !expedited && n_room;
	assign e_we = take && !func && async_q && expedited
		&& eocc_q < ECW'(EXPEDITED_DEPTH);

	aptq_ram #(.WIDTH(DW), .DEPTH(NORMAL_DEPTH)) u_nram (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(wdesc),
		.raddr(nhead_q), .rdata(n_rdata));

	aptq_ram #(.WIDTH(DW), .DEPTH(EXPEDITED_DEPTH)) u_eram (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(wdesc),
		.raddr(ehead_q), .rdata(e_rdata));

	aptq_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		unique case (paddr[4:2])
			REG_ASYNC:  prdata = {31'd0, async_q};
			REG_LIMIT:  prdata = {22'd0, qlimit_q};
			REG_RESIZE: prdata = {31'd0, resize_q};
			REG_DELAY:  prdata = {16'd0, delay_q};
			REG_RATE:   prdata = rate_q;
			default:    prdata = 32'd0;
		endcase
	end

	// divider launches
	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = '0;
		dreq.den   = '0;
		if (state_q == S_MUL && desc_q[16:1] != 16'd0) begin
			dreq.start = 1'b1;
			dreq.num   = {16'd0, num_q};
			dreq.den   = 48'(desc_q[16:1]) * 48'd1000;
		end else if (state_q == S_LEVEL) begin
			dreq.start = 1'b1;
			dreq.num   = 64'(nocc_q) * 64'd255;
			dreq.den   = 48'(alimit_q);
		end
	end

	logic [9:0] inc_lim, dec_lim, grow_lim;
	assign inc_lim  = alimit_q + 10'd1;
	assign dec_lim  = (alimit_q - 10'd1 > 10'(LIMIT_FLOOR)) ? alimit_q - 10'd1
		: 10'(LIMIT_FLOOR);
	assign grow_lim = (qlimit_q != 10'd0 && inc_lim > qlimit_q) ? qlimit_q
		: (inc_lim > 10'(NORMAL_DEPTH) ? 10'(NORMAL_DEPTH) : inc_lim);

	logic need_level;
	assign need_level = async_q && alimit_q != 10'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			async_q  <= 1'b1;
			qlimit_q <= 10'd300;
			alimit_q <= 10'd300;
			resize_q <= 1'b0;
			delay_q  <= 16'd3000;
			rate_q   <= '0;
			nhead_q  <= '0;
			nocc_q   <= '0;
			ehead_q  <= '0;
			eocc_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr) begin
				unique case (paddr[4:2])
					REG_ASYNC:  async_q <= pwdata[0];
					REG_LIMIT: begin
						qlimit_q <= (pwdata[9:0] > 10'(NORMAL_DEPTH)) ?
							10'(NORMAL_DEPTH) : pwdata[9:0];
						alimit_q <= (pwdata[9:0] > 10'(NORMAL_DEPTH)) ?
							10'(NORMAL_DEPTH) : pwdata[9:0];
					end
					REG_RESIZE: resize_q <= pwdata[0];
					REG_DELAY:  delay_q <= (pwdata[15:0] < 16'd100) ? 16'd100
						: pwdata[15:0];
					REG_RATE:   rate_q <= pwdata;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (take) begin
					state_q <= S_READ;
					if (!func) begin
						if (!async_q) st_q <= ST_BYPASS;
						else if (e_we || n_we) st_q <= ST_ACCEPTED;
						else st_q <= ST_FULL;
						if (e_we) eocc_q <= eocc_q + ECW'(1);
						if (n_we) nocc_q <= nocc_q + NCW'(1);
					end else if (eocc_q != '0) begin
						st_q       <= ST_DEQUEUED;
						from_exp_q <= 1'b1;
						ehead_q    <= ehead_q + EAW'(1);
						eocc_q     <= eocc_q - ECW'(1);
					end else if (nocc_q != '0) begin
						st_q       <= ST_DEQUEUED;
						from_exp_q <= 1'b0;
						nhead_q    <= nhead_q + NAW'(1);
						nocc_q     <= nocc_q - NCW'(1);
					end else begin
						st_q <= ST_EMPTY;
					end
				end
				S_READ: begin
					if (st_q == ST_DEQUEUED && resize_q) state_q <= S_MUL;
					else if (need_level) state_q <= S_LEVEL;
					else state_q <= S_OUT;
				end
				S_MUL: begin
					if (desc_q[16:1] == 16'd0) begin
						alimit_q <= grow_lim;
						state_q  <= S_WAITL;
					end else begin
						state_q <= S_BOUND;
					end
				end
				S_BOUND: if (drsp.done) begin
					if (drsp.quo < 64'(alimit_q)) alimit_q <= dec_lim;
					else alimit_q <= grow_lim;
					state_q <= S_WAITL;
				end
				S_WAITL: state_q <= need_level ? S_LEVEL : S_OUT;
				S_LEVEL: state_q <= S_OUT;
				S_OUT: if (!need_level || drsp.done) begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			addr_q <= dest_addr;
			len_q  <= msg_length;
		end
		if (state_q == S_READ) begin
			desc_q <= from_exp_q ? e_rdata : n_rdata;
			num_q  <= 48'(delay_q) * 48'(rate_q);
		end
	end

	// result register
	logic [7:0] lvl_val;
	always_comb begin
		if (!async_q) lvl_val = 8'd0;
		else if (alimit_q == 10'd0)
			lvl_val = (nocc_q > NCW'(255)) ? 8'd255 : 8'(nocc_q);
		else lvl_val = (drsp.quo > 64'd255) ? 8'd255 : drsp.quo[7:0];
	end

	logic dq;
	assign dq = (st_q == ST_DEQUEUED);

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!need_level || drsp.done)) begin
			status             <= st_q;
			out_addr           <= dq ? desc_q[48:17] :
				(st_q == ST_BYPASS ? addr_q : 32'd0);
			out_length         <= dq ? desc_q[16:1] :
				(st_q == ST_BYPASS ? len_q : 16'd0);
			out_wants_level    <= dq && desc_q[0];
			out_from_expedited <= dq && from_exp_q;
			scaled_level       <= lvl_val;
			normal_count       <= 10'(nocc_q);
			current_limit      <= alimit_q;
		end
	end

	assign done = done_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nocc_q <= NCW'(NORMAL_DEPTH) && eocc_q <= ECW'(EXPEDITED_DEPTH))
		else $error("occupancy over depth");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(n_we && e_we)) else $error("both stores written");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE) else $error("result while busy");
	a_limit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		alimit_q <= 10'(NORMAL_DEPTH)) else $error("limit over depth");
endmodule

[tb/adaptive_priority_tx_queue_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adaptive_priority_tx_queue_checker
// Watches the command and result beats, predicts each result from its own
// copy of both queues, the adaptive limit and the registers, and compares.
// ----------------------------------------------------------------------------
module adaptive_priority_tx_queue_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        start,
	input  logic        busy,
	input  logic        func,
	input  logic        expedited,
	input  logic [31:0] dest_addr,
	input  logic [15:0] msg_length,
	input  logic        wants_level,
	input  logic        done,
	input  logic [2:0]  status,
	input  logic [31:0] out_addr,
	input  logic [15:0] out_length,
	input  logic        out_wants_level,
	input  logic        out_from_expedited,
	input  logic [7:0]  scaled_level,
	input  logic [9:0]  normal_count,
	input  logic [9:0]  current_limit,
	output int          fail_count,
	output int          pending,
	output int          beats_seen
);
	import aptq_pkg::*;

	typedef struct {
		logic [31:0] addr;
		logic [15:0] len;
		logic        lvl;
	} desc_t;

	typedef struct {
		logic [2:0]  st;
		logic [31:0] addr;
		logic [15:0] len;
		logic        lvl;
		logic        expd;
		logic [7:0]  level;
		logic [9:0]  count;
		logic [9:0]  limit;
	} txq_result_t;

	desc_t       normal_q[$];
	desc_t       exped_q[$];
	txq_result_t expected_results[$];
	int          adapt_lim, q_lim, delay_ms;
	bit          async_on, resize_on;
	longint unsigned rate;

	function automatic void adapt_limit(int len);
		bit              shrink;
		longint unsigned bound;
		shrink = 0;
		if (len != 0) begin
			bound = (longint'(delay_ms) * rate) / (longint'(len) * 1000);
			shrink = bound < longint'(adapt_lim);
		end
		if (shrink)
			adapt_lim = (adapt_lim - 1 > LIMIT_FLOOR) ? adapt_lim - 1 : LIMIT_FLOOR;
		else begin
			adapt_lim++;
			if (q_lim > 0 && adapt_lim > q_lim)
				adapt_lim = q_lim;
		end
		if (adapt_lim > NORMAL_DEPTH)
			adapt_lim = NORMAL_DEPTH;
	endfunction

	function automatic txq_result_t predict_txq(bit f, bit ex, logic [31:0] a,
			logic [15:0] l, bit w);
		txq_result_t r;
		desc_t       d;
		int          v;
		bit          got;
		r = '{default: '0};
		if (!f) begin
			if (!async_on) begin
				r.st = ST_BYPASS;
				r.addr = a;
				r.len = l;
			end else if (ex) begin
				if (exped_q.size() >= EXPEDITED_DEPTH)
					r.st = ST_FULL;
				else begin
					exped_q.push_back('{a, l, w});
					r.st = ST_ACCEPTED;
				end
			end else if ((adapt_lim == 0 || normal_q.size() < adapt_lim) &&
					normal_q.size() < NORMAL_DEPTH) begin
				normal_q.push_back('{a, l, w});
				r.st = ST_ACCEPTED;
			end else
				r.st = ST_FULL;
		end else begin
			got = 1;
			if (exped_q.size() > 0) begin
				d = exped_q.pop_front();
				r.expd = 1;
			end else if (normal_q.size() > 0)
				d = normal_q.pop_front();
			else
				got = 0;
			if (!got) begin
				r.st = ST_EMPTY;
			end else begin
				r.st = ST_DEQUEUED;
				r.addr = d.addr;
				r.len = d.len;
				r.lvl = d.lvl;
				if (resize_on)
					adapt_limit(d.len);
			end
		end
		if (!async_on)
			v = 0;
		else if (adapt_lim > 0)
			v = normal_q.size() * 255 / adapt_lim;
		else
			v = normal_q.size();
		r.level = (v > 255) ? 8'd255 : v[7:0];
		r.count = normal_q.size();
		r.limit = adapt_lim;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		txq_result_t e;
		int          v;
		if (!arst_n) begin
			normal_q.delete();
			exped_q.delete();
			expected_results.delete();
			async_on = 1;
			q_lim = 300;
			adapt_lim = 300;
			resize_on = 0;
			delay_ms = 3000;
			rate = 0;
			fail_count = 0;
			pending = 0;
			beats_seen = 0;
		end else begin
			if (done) begin
				beats_seen++;
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: result beat with none expected, status %0d", $time, status);
				end else begin
					e = expected_results.pop_front();
					if ({status, out_addr, out_length, out_wants_level, out_from_expedited,
							scaled_level, normal_count, current_limit} !==
							{e.st, e.addr, e.len, e.lvl, e.expd, e.level, e.count, e.limit}) begin
						fail_count++;
						$display("%0t: expected st=%0d addr=%h len=%0d lvl=%0d exp=%0d lev=%0d cnt=%0d lim=%0d",
							$time, e.st, e.addr, e.len, e.lvl, e.expd, e.level, e.count, e.limit);
						$display("%0t: actual   st=%0d addr=%h len=%0d lvl=%0d exp=%0d lev=%0d cnt=%0d lim=%0d",
							$time, status, out_addr, out_length, out_wants_level, out_from_expedited,
							scaled_level, normal_count, current_limit);
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_ASYNC:  async_on = pwdata[0];
					REG_LIMIT: begin
						v = pwdata[9:0];
						q_lim = (v > NORMAL_DEPTH) ? NORMAL_DEPTH : v;
						adapt_lim = q_lim;
					end
					REG_RESIZE: resize_on = pwdata[0];
					REG_DELAY: begin
						v = pwdata[15:0];
						delay_ms = (v < 100) ? 100 : v;
					end
					REG_RATE:   rate = pwdata;
					default: ;
				endcase
			end
			if (start && !busy)
				expected_results.push_back(predict_txq(func, expedited, dest_addr, msg_length,
					wants_level));
			pending = expected_results.size();
		end
	end

endmodule

[tb/adaptive_priority_tx_queue_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adaptive_priority_tx_queue_tb
// Drives enqueue and dequeue commands and register writes into the transmit
// queue under varying sender gaps; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module adaptive_priority_tx_queue_tb;
	import aptq_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        start, busy;
	logic        func, expedited, wants_level;
	logic [31:0] dest_addr;
	logic [15:0] msg_length;
	logic        done;
	logic [2:0]  status;
	logic [31:0] out_addr;
	logic [15:0] out_length;
	logic        out_wants_level, out_from_expedited;
	logic [7:0]  scaled_level;
	logic [9:0]  normal_count, current_limit;
	int          fail_count, pending, beats_seen;
	int          cycle_count;
	int          idle_pct;
	int          n_cmds;

	adaptive_priority_tx_queue u_dut (.*);

	adaptive_priority_tx_queue_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 3000000) begin
			$display("adaptive_priority_tx_queue: mismatch");
			$finish;
		end
	end

	// start stays high after a beat until the next command or drain_wait
	task automatic send_cmd(bit f, bit ex, logic [31:0] a, logic [15:0] l, bit w);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		func <= f;
		expedited <= ex;
		dest_addr <= a;
		msg_length <= l;
		wants_level <= w;
		do
			@(posedge clk);
		while (busy);
		n_cmds++;
	endtask

	task automatic drain_wait;
		start <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (200)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		@(posedge clk);
	endtask

	task automatic rand_cmd(int enq_pct, int exp_pct);
		bit f;
		f = $urandom_range(99) >= enq_pct;
		send_cmd(f, $urandom_range(99) < exp_pct, $urandom,
			($urandom_range(9) == 0) ? 16'($urandom_range(1)) : 16'($urandom),
			$urandom_range(1));
	endtask

	task automatic rand_phase(int n, int enq_pct, int exp_pct);
		repeat (n)
			rand_cmd(enq_pct, exp_pct);
	endtask

	initial begin
		cycle_count = 0;
		n_cmds = 0;
		idle_pct = 0;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		start = 0; func = 0; expedited = 0; dest_addr = 0; msg_length = 0;
		wants_level = 0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty, both classes, extremes, priority, bypass
		send_cmd(1, 0, 0, 0, 0);
		send_cmd(0, 0, 32'hFFFF_FFFF, 16'hFFFF, 1);
		send_cmd(0, 1, 32'h0000_0000, 16'h0000, 0);
		send_cmd(0, 1, 32'hA5A5_5A5A, 16'h8001, 1);
		send_cmd(1, 0, 0, 0, 0);
		send_cmd(1, 0, 0, 0, 0);
		send_cmd(1, 0, 0, 0, 0);
		send_cmd(1, 0, 0, 0, 0);
		drain_wait();
		write_reg(REG_ASYNC, 0);
		send_cmd(0, 0, 32'h1234_5678, 16'hBEEF, 1);
		send_cmd(0, 1, 32'hFFFF_FFFF, 16'hFFFF, 1);
		drain_wait();
		write_reg(REG_ASYNC, 1);
		send_cmd(0, 0, 32'h5A5A_A5A5, 16'h0000, 1);
		drain_wait();
		write_reg(REG_ASYNC, 0);
		send_cmd(1, 0, 0, 0, 0);
		send_cmd(1, 0, 0, 0, 0);
		drain_wait();
		write_reg(REG_ASYNC, 1);
		write_reg(REG_RESIZE, 1);
		write_reg(REG_DELAY, 32'hFFFF_0005);
		write_reg(REG_RATE, 32'hFFFF_FFFF);
		write_reg(REG_LIMIT, 0);
		send_cmd(0, 0, 32'h0000_0001, 16'h0000, 0);
		send_cmd(0, 0, 32'h0000_0002, 16'h0001, 1);
		send_cmd(1, 0, 0, 0, 0);
		send_cmd(1, 0, 0, 0, 0);
		drain_wait();

		// expedited overflow, normal limit overflow
		write_reg(REG_RESIZE, 0);
		write_reg(REG_LIMIT, 10);
		rand_phase(80, 100, 90);
		rand_phase(80, 0, 0);
		drain_wait();
		// limit write above depth clamps; fill normal to depth
		write_reg(REG_LIMIT, 1023);
		rand_phase(530, 100, 0);
		drain_wait();

		// sender idles 24 percent
		idle_pct = 24;
		write_reg(REG_RESIZE, 1);
		write_reg(REG_RATE, 32'd2_000_000);
		write_reg(REG_DELAY, 32'd100);
		write_reg(REG_LIMIT, 64);
		rand_phase(150, 55, 20);
		drain_wait();
		write_reg(REG_RATE, 0);
		write_reg(REG_LIMIT, 5);
		rand_phase(100, 50, 10);
		drain_wait();

		// sender idles 59 percent
		idle_pct = 59;
		write_reg(REG_RATE, 32'd50_000_000);
		write_reg(REG_DELAY, 32'd65535);
		write_reg(REG_LIMIT, 512);
		rand_phase(150, 60, 25);
		drain_wait();

		// everything back to back
		idle_pct = 0;
		write_reg(REG_LIMIT, 1);
		write_reg(REG_RESIZE, 0);
		rand_phase(60, 60, 10);
		drain_wait();
		write_reg(REG_RESIZE, 1);
		write_reg(REG_RATE, 32'd30_000);
		write_reg(REG_DELAY, 32'd1000);
		write_reg(REG_LIMIT, 40);
		rand_phase(250, 55, 15);
		drain_wait();
		write_reg(REG_ASYNC, 0);
		rand_phase(60, 50, 50);
		drain_wait();
		write_reg(REG_ASYNC, 1);
		write_reg(REG_LIMIT, 300);
		write_reg(REG_RATE, $urandom);
		write_reg(REG_DELAY, $urandom);
		rand_phase(250, 50, 20);
		drain_wait();

		$display("covered %0d commands, %0d result beats: bypass, overflow of both classes,",
			n_cmds, beats_seen);
		$display("limits 0..512 and adaptive resize at several rates and delays");
		if (fail_count == 0)
			$display("adaptive_priority_tx_queue: match");
		else
			$display("adaptive_priority_tx_queue: mismatch");
		$finish;
	end

endmodule

[files.f]
hdl/aptq_pkg.sv
hdl/aptq_ram.sv
hdl/aptq_div.sv
hdl/adaptive_priority_tx_queue.sv
tb/adaptive_priority_tx_queue_checker.sv
tb/adaptive_priority_tx_queue_tb.sv
